/* rtl/cpa_pkg.sv */
// Shared types, codes and defaults of the contiguous page allocator.
`default_nettype none

package cpa_pkg;

  localparam int unsigned MaxPagesDef     = 256;
  localparam int unsigned PageSizeLog2Def = 12;

  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_USABLE_PAGES = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_ADDRESS = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [8:0] UsablePagesRst = 9'd256;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ZERO    = 3'd1,
    ST_NOSPACE = 3'd2,
    ST_RANGE   = 3'd3,
    ST_BADFREE = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic        req_type;
    logic [8:0]  page_count;
    logic [31:0] free_address;
  } cpa_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  first_page;
    logic [31:0] page_address;
    logic [8:0]  pages_freed;
  } cpa_out_t;

  typedef struct packed {
    logic [8:0]  usable_pages;
    logic [31:0] base_address;
  } cpa_cfg_t;

  typedef struct packed {
    logic taken;
    logic last;
  } flag_t;

endpackage

`default_nettype wire

/* rtl/contiguous_page_allocator_core.sv */
// Top level of the first-fit contiguous page allocator.
//
//   channel   handshake                 payload                       role
//   in        in_valid_i / in_ready_o   in_data_i   (cpa_in_t)        allocate or free request
//   out       out_valid_o / out_ready_i out_data_o  (cpa_out_t)       one result word per request
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i       register writes
//
// One request at a time. An allocate checks the request, scans for the first free run and
// marks it taken; a free checks the address, walks to the last page of its run and clears
// it. Each scanned page passes through a read step and a judge step on the registered flag
// memory read. After reset a clearing pass writes every page free; no request word is taken
// meanwhile, configuration words are. A finished result waits in the output register; the
// sequencer holds in its done step until that register takes it.
`default_nettype none

module contiguous_page_allocator_core #(
  parameter int unsigned MAX_PAGES      = cpa_pkg::MaxPagesDef,
  parameter int unsigned PAGE_SIZE_LOG2 = cpa_pkg::PageSizeLog2Def
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire cpa_pkg::cpa_in_t              in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output cpa_pkg::cpa_out_t                  out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cpa_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]                   cfg_data_i
);

  localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  cpa_pkg::cpa_cfg_t cfg_q, cfg_d;
  cpa_pkg::cpa_out_t out_q;
  logic              out_valid_q, out_valid_d;

  logic              res_valid;
  logic              res_taken;
  cpa_pkg::cpa_out_t res;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  cpa_pkg::flag_t    ram_wdata;
  logic [AW-1:0]     ram_raddr;
  cpa_pkg::flag_t    ram_rdata;

  // Configuration writes are always taken; the user keeps the block idle whenever they arrive.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cpa_pkg::CFG_USABLE_PAGES: cfg_d.usable_pages = cfg_data_i[8:0];
        cpa_pkg::CFG_BASE_ADDRESS: cfg_d.base_address = cfg_data_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  // Load the output register when it is empty or being drained this cycle.
  assign res_taken = res_valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_taken) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.usable_pages <= cpa_pkg::UsablePagesRst;
      cfg_q.base_address <= '0;
      out_valid_q        <= 1'b0;
    end else begin
      cfg_q              <= cfg_d;
      out_valid_q        <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_taken) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  cpa_engine #(
    .MAX_PAGES      (MAX_PAGES),
    .PAGE_SIZE_LOG2 (PAGE_SIZE_LOG2),
    .AW             (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (in_ready_o),
    .req_i       (in_data_i),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_taken_i (res_taken),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  cpa_flag_ram #(
    .MAX_PAGES (MAX_PAGES),
    .AW        (AW)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // An accepted request makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while previous request still busy");

  // Flag writes happen only during the clearing pass or while a request is in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !in_ready_o)
    else $error("flag memory written while idle");

  // Failed requests carry zeros in the first page, page address and pages freed fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != cpa_pkg::ST_OK) |->
      (out_data_o.first_page == 8'd0) && (out_data_o.page_address == 32'd0) &&
      (out_data_o.pages_freed == 9'd0))
    else $error("failed request returned nonzero result fields");

  // A result is only produced while no request word can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !in_ready_o)
    else $error("result pending while request port is open");

endmodule

`default_nettype wire

/* rtl/cpa_flag_ram.sv */
// Flag memory: one taken/last pair per page, one write and one registered read port.
`default_nettype none

module cpa_flag_ram #(
  parameter int unsigned MAX_PAGES = cpa_pkg::MaxPagesDef,
  parameter int unsigned AW        = 8
) (
  input  wire logic            clk_i,
  input  wire logic            we_i,
  input  wire logic [AW-1:0]   waddr_i,
  input  wire cpa_pkg::flag_t  wdata_i,
  input  wire logic [AW-1:0]   raddr_i,
  output cpa_pkg::flag_t       rdata_o
);

  cpa_pkg::flag_t mem [MAX_PAGES];
  cpa_pkg::flag_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/cpa_engine.sv */
// Sequencer of the allocator: clearing pass, range checks, page scan and run marking or clearing.
`default_nettype none

module cpa_engine #(
  parameter int unsigned MAX_PAGES      = cpa_pkg::MaxPagesDef,
  parameter int unsigned PAGE_SIZE_LOG2 = cpa_pkg::PageSizeLog2Def,
  parameter int unsigned AW             = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire cpa_pkg::cpa_in_t  req_i,
  input  wire cpa_pkg::cpa_cfg_t cfg_i,
  output logic                   res_valid_o,
  input  wire logic              res_taken_i,
  output cpa_pkg::cpa_out_t      res_o,
  output logic                   ram_we_o,
  output logic [AW-1:0]          ram_waddr_o,
  output cpa_pkg::flag_t         ram_wdata_o,
  output logic [AW-1:0]          ram_raddr_o,
  input  wire cpa_pkg::flag_t    ram_rdata_i
);

  localparam int unsigned CW = $clog2(MAX_PAGES + 1);

  cpa_pkg::state_e  state_q, state_d;
  cpa_pkg::cpa_in_t req_q, req_d;
  cpa_pkg::status_e status_q, status_d;
  logic [CW-1:0]    lim_q, lim_d;
  logic [CW-1:0]    ptr_q, ptr_d;
  logic [CW-1:0]    start_q, start_d;
  logic [CW-1:0]    end_q, end_d;
  logic [8:0]       run_len_q, run_len_d;

  logic              is_free;
  logic [31:0]       lim_w;
  logic [31:0]       idx_w;
  logic              chk_fail;
  cpa_pkg::status_e  chk_status;
  logic [CW-1:0]     ptr_inc;
  logic              at_end;
  logic              ev_hit;
  logic              ev_fail;
  logic              wr_last;
  logic              res_ok;

  // Request checks: limit capped at the array depth, address turned into a page index.
  always_comb begin
    is_free    = (req_q.req_type == cpa_pkg::REQ_FREE);
    lim_w      = (32'(cfg_i.usable_pages) > 32'(MAX_PAGES)) ? 32'(MAX_PAGES)
                                                             : 32'(cfg_i.usable_pages);
    idx_w      = (req_q.free_address - cfg_i.base_address) >> PAGE_SIZE_LOG2;
    chk_fail   = 1'b0;
    chk_status = cpa_pkg::ST_OK;
    if (!is_free) begin
      if (req_q.page_count == 9'd0) begin
        chk_fail   = 1'b1;
        chk_status = cpa_pkg::ST_ZERO;
      end else if (32'(req_q.page_count) > lim_w) begin
        chk_fail   = 1'b1;
        chk_status = cpa_pkg::ST_NOSPACE;
      end
    end else begin
      if (req_q.free_address < cfg_i.base_address || idx_w >= lim_w) begin
        chk_fail   = 1'b1;
        chk_status = cpa_pkg::ST_RANGE;
      end
    end
  end

  // Scan step: judge the page just read.
  always_comb begin
    ptr_inc = ptr_q + 1'b1;
    at_end  = (ptr_inc == lim_q);
    wr_last = (ptr_q == end_q);
    if (!is_free) begin
      ev_hit  = !ram_rdata_i.taken && ((run_len_q + 9'd1) == req_q.page_count);
      ev_fail = !ev_hit && at_end;
    end else begin
      ev_hit  = ram_rdata_i.taken && ram_rdata_i.last;
      ev_fail = !ram_rdata_i.taken || (!ram_rdata_i.last && at_end);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cpa_pkg::S_CLEAR: begin
        if (ptr_q == CW'(MAX_PAGES - 1)) begin
          state_d = cpa_pkg::S_IDLE;
        end
      end
      cpa_pkg::S_IDLE: begin
        if (req_valid_i) begin
          state_d = cpa_pkg::S_CHECK;
        end
      end
      cpa_pkg::S_CHECK: begin
        state_d = chk_fail ? cpa_pkg::S_DONE : cpa_pkg::S_READ;
      end
      cpa_pkg::S_READ: begin
        state_d = cpa_pkg::S_EVAL;
      end
      cpa_pkg::S_EVAL: begin
        if (ev_hit) begin
          state_d = cpa_pkg::S_WRITE;
        end else if (ev_fail) begin
          state_d = cpa_pkg::S_DONE;
        end else begin
          state_d = cpa_pkg::S_READ;
        end
      end
      cpa_pkg::S_WRITE: begin
        if (wr_last) begin
          state_d = cpa_pkg::S_DONE;
        end
      end
      cpa_pkg::S_DONE: begin
        if (res_taken_i) begin
          state_d = cpa_pkg::S_IDLE;
        end
      end
      default: state_d = cpa_pkg::S_IDLE;
    endcase
  end

  // Datapath registers.
  always_comb begin
    req_d     = req_q;
    status_d  = status_q;
    lim_d     = lim_q;
    ptr_d     = ptr_q;
    start_d   = start_q;
    end_d     = end_q;
    run_len_d = run_len_q;
    unique case (state_q)
      cpa_pkg::S_CLEAR: begin
        ptr_d = ptr_inc;
      end
      cpa_pkg::S_IDLE: begin
        if (req_valid_i) begin
          req_d = req_i;
        end
      end
      cpa_pkg::S_CHECK: begin
        lim_d     = CW'(lim_w);
        status_d  = chk_status;
        run_len_d = 9'd0;
        if (is_free) begin
          ptr_d   = CW'(idx_w);
          start_d = CW'(idx_w);
        end else begin
          ptr_d   = '0;
          start_d = '0;
        end
      end
      cpa_pkg::S_EVAL: begin
        if (!is_free) begin
          if (ram_rdata_i.taken) begin
            run_len_d = 9'd0;
            start_d   = ptr_inc;
          end else begin
            run_len_d = run_len_q + 9'd1;
          end
        end
        if (ev_hit) begin
          end_d = ptr_q;
          ptr_d = is_free ? start_q : start_q;
        end else if (ev_fail) begin
          status_d = is_free ? cpa_pkg::ST_BADFREE : cpa_pkg::ST_NOSPACE;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      cpa_pkg::S_WRITE: begin
        if (wr_last) begin
          status_d = cpa_pkg::ST_OK;
        end else begin
          ptr_d = ptr_inc;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cpa_pkg::S_CLEAR;
      ptr_q     <= '0;
      status_q  <= cpa_pkg::ST_OK;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      status_q  <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    lim_q     <= lim_d;
    start_q   <= start_d;
    end_q     <= end_d;
    run_len_q <= run_len_d;
  end

  // Outputs.
  always_comb begin
    req_ready_o       = (state_q == cpa_pkg::S_IDLE);
    res_valid_o       = (state_q == cpa_pkg::S_DONE);
    ram_raddr_o       = ptr_q[AW-1:0];
    ram_waddr_o       = ptr_q[AW-1:0];
    ram_we_o          = (state_q == cpa_pkg::S_CLEAR) || (state_q == cpa_pkg::S_WRITE);
    ram_wdata_o.taken = (state_q == cpa_pkg::S_WRITE) && !is_free;
    ram_wdata_o.last  = (state_q == cpa_pkg::S_WRITE) && !is_free && wr_last;

    res_ok            = (status_q == cpa_pkg::ST_OK);
    res_o.status      = status_q;
    res_o.first_page  = '0;
    res_o.page_address = '0;
    res_o.pages_freed = '0;
    if (res_ok && !is_free) begin
      res_o.first_page   = 8'(start_q);
      res_o.page_address = cfg_i.base_address + (32'(start_q) << PAGE_SIZE_LOG2);
    end
    if (res_ok && is_free) begin
      res_o.pages_freed = 9'(32'(end_q) - 32'(start_q) + 32'd1);
    end
  end

endmodule

`default_nettype wire
